// ===== sv/b64d_pkg.sv =====
// shared types and character constants for the base64 stream decoder
package b64d_pkg;

    // character codes the classifier and decoder care about
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_UNDER   = 8'h5f;
    localparam logic [7:0] CHAR_PAD     = 8'h3d;

    // sextet offsets of the alphabet ranges
    localparam logic [5:0] OFS_LOWER = 6'd26;
    localparam logic [5:0] OFS_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    // masks for splitting sextets into byte pieces
    localparam logic [5:0] MASK_HI2  = 6'h30;
    localparam logic [5:0] MASK_HI4  = 6'h3c;
    localparam logic [5:0] MASK_LO4  = 6'h0f;
    localparam logic [5:0] MASK_LO2  = 6'h03;

    // classified character passed from front to back
    typedef struct packed {
        logic [5:0] sextet;
        logic       bad;
        logic       last;
    } b64d_sym_t;

    localparam int SYM_W = $bits(b64d_sym_t);

    // one result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       stopped_early;
    } b64d_res_t;

endpackage

// ===== sv/b64d_front.sv =====
// front end: accepts characters, holds the alphabet mode, classifies into sextets
module b64d_front
    import b64d_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,     // char_code
    input  logic            s_tlast,     // last_char
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,    // url_safe_alphabet
    output logic            push_valid,
    input  logic            push_ready,
    output b64d_sym_t       push_data
);

    logic url_safe_reg;
    logic url_safe_next;

    // alphabet mode register
    always_comb begin
        url_safe_next = url_safe_reg;
        if (cfg_valid) begin
            url_safe_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_safe_reg <= 1'b0;
        end else begin
            url_safe_reg <= url_safe_next;
        end
    end

    assign cfg_ready = 1'b1;

    // character classification
    logic [7:0] ofs_upper;
    logic [7:0] ofs_lower;
    logic [7:0] ofs_digit;

    assign ofs_upper = s_tdata - CHAR_UPPER_A;
    assign ofs_lower = s_tdata - CHAR_LOWER_A;
    assign ofs_digit = s_tdata - CHAR_DIGIT_0;

    always_comb begin
        push_data.sextet = '0;
        push_data.bad    = 1'b0;
        push_data.last   = s_tlast;
        if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_Z) begin
            push_data.sextet = ofs_upper[5:0];
        end else if (s_tdata >= CHAR_LOWER_A && s_tdata <= CHAR_LOWER_Z) begin
            push_data.sextet = ofs_lower[5:0] + OFS_LOWER;
        end else if (s_tdata >= CHAR_DIGIT_0 && s_tdata <= CHAR_DIGIT_9) begin
            push_data.sextet = ofs_digit[5:0] + OFS_DIGIT;
        end else if (s_tdata == CHAR_PLUS) begin
            push_data.sextet = SEXTET_62;
        end else if (s_tdata == CHAR_SLASH) begin
            push_data.sextet = SEXTET_63;
        end else if (url_safe_reg && s_tdata == CHAR_MINUS) begin
            push_data.sextet = SEXTET_62;
        end else if (url_safe_reg && s_tdata == CHAR_UNDER) begin
            push_data.sextet = SEXTET_63;
        end else begin
            // pad and anything outside the alphabet halt the string
            push_data.bad = 1'b1;
        end
    end

    // request handshake straight into the queue
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ===== sv/b64d_queue.sv =====
// small fifo between the classifier and the decoder
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  b64d_sym_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output b64d_sym_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64d_sym_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/b64d_back.sv =====
// back end: group state, byte assembly and the output register
module b64d_back
    import b64d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  b64d_sym_t pop_data,
    output logic      res_valid,
    input  logic      res_ready,
    output b64d_res_t res_data
);

    logic [5:0] prev_reg, prev_next;
    logic [1:0] pos_reg, pos_next;
    logic       halted_reg, halted_next;
    logic       out_valid_reg, out_valid_next;
    b64d_res_t  out_reg, out_next;
    logic       do_pop;

    // take a symbol whenever the output register is free or draining
    assign pop_ready = !out_valid_reg || res_ready;
    assign do_pop    = pop_valid && pop_ready;

    // decode step
    always_comb begin
        logic [7:0] data;
        logic       has_byte;
        logic       halt_now;
        data           = '0;
        has_byte       = 1'b0;
        halt_now       = halted_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        halted_next    = halted_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (do_pop) begin
            if (!halted_reg) begin
                if (pop_data.bad) begin
                    halt_now = 1'b1;
                end else begin
                    case (pos_reg)
                        2'd1: begin
                            data     = {prev_reg, 2'b00}
                                     | {6'd0, 2'((pop_data.sextet & MASK_HI2) >> 4)};
                            has_byte = 1'b1;
                        end
                        2'd2: begin
                            data     = {(prev_reg & MASK_LO4), 2'b00} << 2;
                            data     = data | {4'd0, 4'((pop_data.sextet & MASK_HI4) >> 2)};
                            has_byte = 1'b1;
                        end
                        2'd3: begin
                            data     = {(prev_reg[1:0] & MASK_LO2[1:0]), pop_data.sextet};
                            has_byte = 1'b1;
                        end
                        default: begin
                            has_byte = 1'b0;
                        end
                    endcase
                    prev_next = pop_data.sextet;
                    pos_next  = pos_reg + 2'd1;
                end
            end
            halted_next = halt_now;
            if (has_byte || pop_data.last) begin
                out_valid_next         = 1'b1;
                out_next.data_byte     = data;
                out_next.byte_valid    = has_byte;
                out_next.end_of_string = pop_data.last;
                out_next.stopped_early = pop_data.last && halt_now;
            end
            // end of string clears the group state
            if (pop_data.last) begin
                prev_next   = '0;
                pos_next    = '0;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            pos_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

// ===== sv/base64_stream_decoder.sv =====
// top level of the base64 stream decoder
//
// Characters enter on the s_ stream, one per request: s_tdata is the raw
// character code, s_tlast marks the final character of a string. Results
// leave on the m_ stream: m_tdata is the decoded byte, m_tuser[0] says a
// byte is present, m_tuser[1] says decoding halted early, m_tlast closes the
// string. A byte appears at the second, third and fourth character of each
// group; the character marked last always yields a result, with or without
// a byte. The cfg channel writes the alphabet mode (1 adds '-' and '_');
// it is always ready and is to be written only while the block is idle.
// Throughput is one character per cycle while the receiver does not stall.
// An accepted character is classified combinationally and written into the
// queue, then decoded from the queue into the output register behind m_tvalid.
// When the receiver stalls, the output register holds its result, the
// decoder stops popping and the queue (QUEUE_DEPTH entries) fills before
// s_tready drops. Reset clears the queue, the group state, the output valid
// and the alphabet mode; there is no clearing pass.
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_code
    input  logic       s_tlast,    // last_char
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,   // url_safe_alphabet
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] data_byte
    output logic [1:0] m_tuser,    // [0] byte_valid, [1] stopped_early
    output logic       m_tlast     // end_of_string
);

    logic      push_valid, push_ready;
    b64d_sym_t push_data;
    logic      pop_valid, pop_ready;
    b64d_sym_t pop_data;
    b64d_res_t res_data;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64d_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_data)
    );

    assign m_tdata    = res_data.data_byte;
    assign m_tuser[0] = res_data.byte_valid;
    assign m_tuser[1] = res_data.stopped_early;
    assign m_tlast    = res_data.end_of_string;

    // early stop is reported only on the closing result
    a_stop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("stopped_early set on a result that does not close the string");

    // a result carries a byte or closes the string
    a_no_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || m_tlast))
        else $error("result with neither byte nor end of string");

    // no byte means a zero data field
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == 8'd0))
        else $error("data byte not zero on a result without a byte");

    // a stalled decoder output keeps the queue from being drained
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !pop_ready)
        else $error("decoder popped while its output was stalled");

endmodule
